[rtl/core/inverse_cdf_table_sampler_assert.svh]
// Assertion helpers; expect clk and rst_n in scope.
`ifndef INVERSE_CDF_TABLE_SAMPLER_ASSERT_SVH
`define INVERSE_CDF_TABLE_SAMPLER_ASSERT_SVH

// same-cycle implication
`define ICDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icdf check failed");

// next-cycle implication
`define ICDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icdf check failed");

`endif

[rtl/core/icdf_pkg.sv]
package icdf_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // word field widths
  localparam int OP_W   = 1;
  localparam int SIDX_W = 10;
  localparam int CDF_W  = 17;
  localparam int VAL_W  = 32;
  localparam int U_W    = 16;
  localparam int CNT_W  = 11;

  // interpolation datapath
  localparam int DU_W      = CDF_W + 1;
  localparam int DV_W      = VAL_W + 1;
  localparam int PROD_W    = DU_W + DV_W;
  localparam int NUM_W     = PROD_W - 1;   // magnitude of the product, even
  localparam int DEN_W     = CDF_W;
  localparam int DIV_STEPS = NUM_W / 2;    // two quotient bits per cycle
  localparam int DSTEP_W   = $clog2(DIV_STEPS);
  localparam int SUM_W     = PROD_W + 1;

  localparam logic [CNT_W-1:0] ENTRIES_RESET = CNT_W'(TABLE_DEPTH);

  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic        [CDF_W-1:0] cdf;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic        [OP_W-1:0]   operation;
    logic        [SIDX_W-1:0] entry_index;
    logic        [CDF_W-1:0]  entry_cdf;
    logic signed [VAL_W-1:0]  entry_value;
    logic        [U_W-1:0]    uniform_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  sampled_value;
    logic        [SIDX_W-1:0] segment_low_index;
    logic                     flat_segment;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

[rtl/core/inverse_cdf_table_sampler.sv]
// Inverse-CDF sampler over a loadable table with linear interpolation.
// Input channel (in_valid / in_stall / in_word): a write word (operation 0)
// stores cdf and value at entry_index and gives no result; a sample word
// (operation 1) gives one result word on the out channel.
// cfg_wr_en / cfg_wr_data set entries_used (clamped to 2..1024); write it
// only while the block is idle.
// Write words are stored as they are taken. On a full 1024-entry table a
// sample runs through one read of the last entry, one table read per
// bisection step (up to ceil(log2(entries_used - 1)), ten here), two reads
// for the bracketing pair, one multiply, a divider start, 25 two-bit divider
// steps and a done flag, and the output state; a flat segment skips the
// multiply and divider. A sample above the last point goes from the
// last-entry read straight to the output state. The single-port table and
// the divider set this sequence; one item is processed at a time.
// in_stall is high while a sample is in progress.
// The result sits in an output register; the next word is taken while it
// waits, but a following sample holds in its last cycle until out_stall
// drops and the register frees.
// Reset (rst_n, synchronous) clears the control and sets entries_used to
// 1024; table contents are undefined until written.
`include "inverse_cdf_table_sampler_assert.svh"

module inverse_cdf_table_sampler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  icdf_pkg::in_word_t         in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output icdf_pkg::out_word_t        out_word,
  input  logic                       cfg_wr_en,
  input  logic [icdf_pkg::CNT_W-1:0] cfg_wr_data
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LAST = 9'b000000010,
    S_BIS  = 9'b000000100,
    S_RLO  = 9'b000001000,
    S_RHI  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_DST  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  icdf_pkg::entry_t mem [icdf_pkg::TABLE_DEPTH];
  icdf_pkg::entry_t rd_q;
  logic [icdf_pkg::IDX_W-1:0] rd_addr;
  logic                       wr_en;

  logic [icdf_pkg::CNT_W-1:0]        entries_used_r;
  logic [icdf_pkg::U_W-1:0]          u_r;
  logic [icdf_pkg::IDX_W-1:0]        lo_r, hi_r, mid_r;
  logic [icdf_pkg::CDF_W-1:0]        c1_r;
  logic signed [icdf_pkg::VAL_W-1:0] v1_r;
  logic signed [icdf_pkg::DU_W-1:0]  den_r, du_r;
  logic signed [icdf_pkg::DV_W-1:0]  dv_r;
  logic signed [icdf_pkg::PROD_W-1:0] prod_r, quo_s_r;
  logic                              neg_r, flat_r;
  logic                              out_valid_r;
  icdf_pkg::out_word_t               out_word_r;

  logic                              in_acc, out_free;
  logic [icdf_pkg::IDX_W-1:0]        last, lo_n, hi_n, mid_n, gap;
  logic [icdf_pkg::IDX_W:0]          mid_sum;
  logic                              wide, above, go_hi;
  logic signed [icdf_pkg::DU_W-1:0]  den_w, du_w;
  logic signed [icdf_pkg::DV_W-1:0]  dv_w;
  logic signed [icdf_pkg::PROD_W-1:0] num_abs, quo_ext;
  logic signed [icdf_pkg::DU_W-1:0]  den_abs;
  logic signed [icdf_pkg::SUM_W-1:0] sum;
  logic [icdf_pkg::VAL_W-1:0]        sat_val;
  icdf_pkg::div_req_t                div_req;
  icdf_pkg::div_rsp_t                div_rsp;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // effective last index
  always_comb begin
    if (entries_used_r < icdf_pkg::CNT_W'(2)) begin
      last = icdf_pkg::IDX_W'(1);
    end else if (entries_used_r > icdf_pkg::CNT_W'(icdf_pkg::TABLE_DEPTH)) begin
      last = icdf_pkg::IDX_W'(icdf_pkg::TABLE_DEPTH - 1);
    end else begin
      last = icdf_pkg::IDX_W'(entries_used_r - icdf_pkg::CNT_W'(1));
    end
  end

  assign above = icdf_pkg::CDF_W'(u_r) > rd_q.cdf;
  assign go_hi = rd_q.cdf > icdf_pkg::CDF_W'(u_r);

  // bisection bounds after this cycle's compare
  always_comb begin
    lo_n = lo_r;
    hi_n = hi_r;
    if (state_r == S_LAST) begin
      lo_n = '0;
      hi_n = last;
    end else if (state_r == S_BIS) begin
      if (go_hi) begin
        hi_n = mid_r;
      end else begin
        lo_n = mid_r;
      end
    end
  end

  assign gap     = hi_n - lo_n;
  assign wide    = gap > icdf_pkg::IDX_W'(1);
  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n   = mid_sum[icdf_pkg::IDX_W:1];

  always_comb begin
    case (state_r)
      S_IDLE:        rd_addr = last;
      S_LAST, S_BIS: rd_addr = wide ? mid_n : lo_n;
      S_RLO:         rd_addr = hi_r;
      default:       rd_addr = lo_r;
    endcase
  end

  assign wr_en = in_acc && (in_word.operation == icdf_pkg::OP_WRITE) &&
                 (32'(in_word.entry_index) < icdf_pkg::TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[icdf_pkg::IDX_W'(in_word.entry_index)] <= '{cdf: in_word.entry_cdf,
                                                       value: in_word.entry_value};
    end
    rd_q <= mem[rd_addr];
  end

  // segment differences
  assign den_w = $signed({1'b0, rd_q.cdf}) - $signed({1'b0, c1_r});
  assign du_w  = $signed({2'b00, u_r}) - $signed({1'b0, c1_r});
  assign dv_w  = $signed({rd_q.value[icdf_pkg::VAL_W-1], rd_q.value}) -
                 $signed({v1_r[icdf_pkg::VAL_W-1], v1_r});

  assign num_abs = prod_r[icdf_pkg::PROD_W-1] ? -prod_r : prod_r;
  assign den_abs = den_r[icdf_pkg::DU_W-1] ? -den_r : den_r;
  assign quo_ext = $signed({1'b0, div_rsp.quo});

  assign div_req.start = (state_r == S_DST);
  assign div_req.num   = num_abs[icdf_pkg::NUM_W-1:0];
  assign div_req.den   = den_abs[icdf_pkg::DEN_W-1:0];

  icdf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // final add and clamp to 32 bits
  assign sum = icdf_pkg::SUM_W'(v1_r) + icdf_pkg::SUM_W'(quo_s_r);
  always_comb begin
    if (sum[icdf_pkg::SUM_W-1] && !(&sum[icdf_pkg::SUM_W-2:icdf_pkg::VAL_W-1])) begin
      sat_val = {1'b1, {(icdf_pkg::VAL_W-1){1'b0}}};
    end else if (!sum[icdf_pkg::SUM_W-1] && (|sum[icdf_pkg::SUM_W-2:icdf_pkg::VAL_W-1])) begin
      sat_val = {1'b0, {(icdf_pkg::VAL_W-1){1'b1}}};
    end else begin
      sat_val = sum[icdf_pkg::VAL_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && in_word.operation == icdf_pkg::OP_SAMPLE) state_nxt = S_LAST;
      S_LAST: begin
        if (above) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = wide ? S_BIS : S_RLO;
        end
      end
      S_BIS:  state_nxt = wide ? S_BIS : S_RLO;
      S_RLO:  state_nxt = S_RHI;
      S_RHI:  state_nxt = (den_w == '0) ? S_OUT : S_MUL;
      S_MUL:  state_nxt = S_DST;
      S_DST:  state_nxt = S_DIV;
      S_DIV:  if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      entries_used_r <= icdf_pkg::ENTRIES_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        entries_used_r <= cfg_wr_data;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        u_r    <= in_word.uniform_sample;
        flat_r <= 1'b0;
      end
      S_LAST: begin
        if (above) begin
          lo_r    <= last;
          v1_r    <= rd_q.value;
          quo_s_r <= '0;
        end else begin
          lo_r  <= lo_n;
          hi_r  <= hi_n;
          mid_r <= mid_n;
        end
      end
      S_BIS: begin
        lo_r  <= lo_n;
        hi_r  <= hi_n;
        mid_r <= mid_n;
      end
      S_RLO: begin
        c1_r <= rd_q.cdf;
        v1_r <= rd_q.value;
      end
      S_RHI: begin
        den_r   <= den_w;
        du_r    <= du_w;
        dv_r    <= dv_w;
        quo_s_r <= '0;
        if (den_w == '0) begin
          flat_r <= 1'b1;
        end
      end
      S_MUL: prod_r <= du_r * dv_r;
      S_DST: neg_r <= prod_r[icdf_pkg::PROD_W-1] ^ den_r[icdf_pkg::DU_W-1];
      S_DIV: begin
        if (div_rsp.done) begin
          quo_s_r <= neg_r ? -quo_ext : quo_ext;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_word_r.sampled_value     <= sat_val;
          out_word_r.segment_low_index <= icdf_pkg::SIDX_W'(lo_r);
          out_word_r.flat_segment      <= flat_r;
        end
      end
      default: ;
    endcase
  end

  `ICDF_ASSERT_NEXT(a_sample_starts,
    in_acc && in_word.operation == icdf_pkg::OP_SAMPLE, state_r == S_LAST)
  `ICDF_ASSERT_NOW(a_bis_order, state_r == S_BIS, (lo_r < mid_r) && (mid_r < hi_r))
  `ICDF_ASSERT_NOW(a_div_done_waited, div_rsp.done, state_r == S_DIV)
  `ICDF_ASSERT_NOW(a_out_from_final, $rose(out_valid_r), $past(state_r) == S_OUT)

endmodule

[rtl/core/icdf_div.sv]
module icdf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  icdf_pkg::div_req_t div_req,
  output icdf_pkg::div_rsp_t div_rsp
);

  logic [icdf_pkg::DEN_W:0]     rem_r;
  logic [icdf_pkg::NUM_W-1:0]   quo_r;
  logic [icdf_pkg::DEN_W-1:0]   den_r;
  logic [icdf_pkg::DSTEP_W-1:0] cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [icdf_pkg::DEN_W:0]     rem_nxt;
  logic [icdf_pkg::NUM_W-1:0]   quo_nxt;

  // restoring division, two bits per cycle, dividend shifts out of quo_r
  always_comb begin
    logic [icdf_pkg::DEN_W:0] r_sh;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < 2; k++) begin
      r_sh    = {rem_nxt[icdf_pkg::DEN_W-1:0], quo_nxt[icdf_pkg::NUM_W-1]};
      quo_nxt = {quo_nxt[icdf_pkg::NUM_W-2:0], 1'b0};
      if (r_sh >= {1'b0, den_r}) begin
        rem_nxt    = r_sh - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = r_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      rem_r <= '0;
      quo_r <= div_req.num;
      den_r <= div_req.den;
      cnt_r <= icdf_pkg::DSTEP_W'(icdf_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - icdf_pkg::DSTEP_W'(1);
    end
  end

  assign div_rsp.done = done_r;
  assign div_rsp.quo  = quo_r;

endmodule
